// ----- hdl/sorted_term_accumulate_table_macros.svh -----
// Assertion helpers used by the checker file
`ifndef SORTED_TERM_ACCUMULATE_TABLE_MACROS_SVH
`define SORTED_TERM_ACCUMULATE_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define STAT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stat check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define STAT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stat check failed");

`endif

// ----- hdl/stat_pkg.sv -----
package stat_pkg;

    // Table geometry
    localparam int MAX_TERMS = 32;
    localparam int OUT_LIMIT = 32;
    localparam int IDX_W     = $clog2(MAX_TERMS);
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);

    // Item kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_INSERT = 2'd0;
    localparam kind_t KIND_DUMP   = 2'd1;
    localparam kind_t KIND_CLEAR  = 2'd2;

    // Result status codes
    typedef logic [2:0] status_t;
    localparam status_t ST_NEW     = 3'd0;
    localparam status_t ST_MERGED  = 3'd1;
    localparam status_t ST_REMOVED = 3'd2;
    localparam status_t ST_ZERO    = 3'd3;
    localparam status_t ST_FULL    = 3'd4;
    localparam status_t ST_TERM    = 3'd5;
    localparam status_t ST_CLEARED = 3'd6;

    // One stored term
    typedef struct packed {
        logic [31:0] coef;
        logic [31:0] exp;
    } entry_t;

    // One result item
    typedef struct packed {
        status_t     status;
        logic [31:0] coef;
        logic [31:0] exp;
        logic        last;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_UP,
        S_PUT,
        S_DN,
        S_DUMP,
        S_DONE
    } state_t;

    // Single-result reply with empty term fields
    function automatic res_t status_res(input status_t st);
        res_t r;
        r.status = st;
        r.coef   = '0;
        r.exp    = '0;
        r.last   = 1'b1;
        return r;
    endfunction

endpackage

// ----- hdl/sorted_term_accumulate_table.sv -----
// Sparse polynomial table: terms are held in one synchronous RAM, sorted by
// descending signed exponent. An insert walks the table one entry per cycle
// from the top until it finds its place, then merges in one write or moves
// the tail up or down one entry per cycle. A dump streams one term per cycle
// after a registered read of the first entry, while the output register can
// take them; clear, zero-coefficient inserts and an insert into an empty
// table go straight to their result. The walk and the moves are bound by the
// single read port of the term RAM. One item is worked on at a time; the
// output register lets the next item in while a result waits. Kind 3 is
// discarded without a result.
module sorted_term_accumulate_table (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] coefficient, [63:32] exponent
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] term_coefficient, [63:32] term_exponent
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);

    logic           res_valid, res_ready;
    stat_pkg::res_t res;
    logic           out_valid_reg, out_valid_next;
    stat_pkg::res_t out_res_reg;

    stat_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_coef   (s_tdata[31:0]),
        .in_exp    (s_tdata[63:32]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: free when empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.exp, out_res_reg.coef};
    assign m_tuser  = out_res_reg.status;
    assign m_tlast  = out_res_reg.last;

endmodule

// ----- hdl/stat_ram.sv -----
module stat_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/stat_seq.sv -----
module stat_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    // input item
    input  logic                  in_valid,
    output logic                  in_ready,
    input  stat_pkg::kind_t       in_kind,
    input  logic [31:0]           in_coef,
    input  logic [31:0]           in_exp,
    // result towards the output register
    output logic                  res_valid,
    input  logic                  res_ready,
    output stat_pkg::res_t        res
);

    localparam int IDX_W = stat_pkg::IDX_W;
    localparam int CNT_W = stat_pkg::CNT_W;

    stat_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [31:0]      coef_reg, coef_next;
    logic [31:0]      exp_reg, exp_next;
    stat_pkg::res_t   pend_reg, pend_next;

    // RAM port signals
    logic                 wr_en, rd_en;
    logic [IDX_W-1:0]     wr_addr, rd_addr;
    stat_pkg::entry_t     wr_entry, rd_entry;

    // Shared compares
    logic             accept;
    logic             gt, eq, full, idx_at_end, dump_end, j_at_pos, j_at_end;
    logic [31:0]      sum;
    logic [CNT_W-1:0] idx_inc, j_inc, dump_n;

    stat_ram #(
        .DEPTH (stat_pkg::MAX_TERMS),
        .WIDTH ($bits(stat_pkg::entry_t))
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    assign in_ready   = (state_reg == stat_pkg::S_IDLE);
    assign accept     = in_valid && in_ready;

    assign gt         = $signed(rd_entry.exp) > $signed(exp_reg);
    assign eq         = rd_entry.exp == exp_reg;
    assign sum        = rd_entry.coef + coef_reg;
    assign full       = count_reg == CNT_W'(stat_pkg::MAX_TERMS);
    assign idx_inc    = CNT_W'(idx_reg) + CNT_W'(1);
    assign j_inc      = CNT_W'(j_reg) + CNT_W'(1);
    assign idx_at_end = idx_inc == count_reg;
    assign j_at_end   = j_inc == count_reg;
    assign j_at_pos   = j_reg == idx_reg;
    assign dump_n     = (count_reg > CNT_W'(stat_pkg::OUT_LIMIT)) ?
                        CNT_W'(stat_pkg::OUT_LIMIT) : count_reg;
    assign dump_end   = idx_inc == dump_n;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stat_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_kind)
                        stat_pkg::KIND_INSERT:
                            state_next = (in_coef == '0 || count_reg == '0) ?
                                         stat_pkg::S_DONE : stat_pkg::S_SEARCH;
                        stat_pkg::KIND_DUMP:
                            state_next = (count_reg == '0) ?
                                         stat_pkg::S_DONE : stat_pkg::S_DUMP;
                        stat_pkg::KIND_CLEAR:
                            state_next = stat_pkg::S_DONE;
                        default:
                            state_next = stat_pkg::S_IDLE;
                    endcase
                end
            end
            stat_pkg::S_SEARCH:
            begin
                if (gt)
                begin
                    state_next = idx_at_end ? stat_pkg::S_DONE : stat_pkg::S_SEARCH;
                end
                else if (eq)
                begin
                    state_next = (sum != '0 || idx_at_end) ?
                                 stat_pkg::S_DONE : stat_pkg::S_DN;
                end
                else
                begin
                    state_next = full ? stat_pkg::S_DONE : stat_pkg::S_UP;
                end
            end
            stat_pkg::S_UP:
                state_next = j_at_pos ? stat_pkg::S_PUT : stat_pkg::S_UP;
            stat_pkg::S_PUT:
                state_next = stat_pkg::S_DONE;
            stat_pkg::S_DN:
                state_next = j_at_end ? stat_pkg::S_DONE : stat_pkg::S_DN;
            stat_pkg::S_DUMP:
                state_next = (res_ready && dump_end) ? stat_pkg::S_IDLE : stat_pkg::S_DUMP;
            stat_pkg::S_DONE:
                state_next = res_ready ? stat_pkg::S_IDLE : stat_pkg::S_DONE;
            default:
                state_next = stat_pkg::S_IDLE;
        endcase
    end

    // Memory accesses, datapath and results
    always_comb
    begin
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_entry.coef = coef_reg;
        wr_entry.exp  = exp_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        j_next        = j_reg;
        coef_next     = coef_reg;
        exp_next      = exp_reg;
        pend_next     = pend_reg;
        res_valid     = 1'b0;
        res           = pend_reg;
        case (state_reg)
            stat_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    coef_next = in_coef;
                    exp_next  = in_exp;
                    idx_next  = '0;
                    case (in_kind)
                        stat_pkg::KIND_INSERT:
                        begin
                            if (in_coef == '0)
                            begin
                                pend_next = stat_pkg::status_res(stat_pkg::ST_ZERO);
                            end
                            else if (count_reg == '0)
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = '0;
                                wr_entry.coef = in_coef;
                                wr_entry.exp  = in_exp;
                                count_next    = CNT_W'(1);
                                pend_next     = stat_pkg::status_res(stat_pkg::ST_NEW);
                            end
                            else
                            begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                            end
                        end
                        stat_pkg::KIND_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_next = stat_pkg::status_res(stat_pkg::ST_CLEARED);
                            end
                            else
                            begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                            end
                        end
                        stat_pkg::KIND_CLEAR:
                        begin
                            count_next = '0;
                            pend_next  = stat_pkg::status_res(stat_pkg::ST_CLEARED);
                        end
                        default:
                        begin
                            pend_next = pend_reg;
                        end
                    endcase
                end
            end
            stat_pkg::S_SEARCH:
            begin
                if (gt)
                begin
                    // stored exponent is higher: step on, or append at the tail (or report full)
                    if (idx_at_end)
                    begin
                        if (full)
                        begin
                            pend_next = stat_pkg::status_res(stat_pkg::ST_FULL);
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = IDX_W'(count_reg);
                            count_next = count_reg + CNT_W'(1);
                            pend_next  = stat_pkg::status_res(stat_pkg::ST_NEW);
                        end
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(idx_inc);
                        idx_next = IDX_W'(idx_inc);
                    end
                end
                else if (eq)
                begin
                    if (sum != '0)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = idx_reg;
                        wr_entry.coef = sum;
                        wr_entry.exp  = rd_entry.exp;
                        pend_next     = stat_pkg::status_res(stat_pkg::ST_MERGED);
                    end
                    else if (idx_at_end)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        pend_next  = stat_pkg::status_res(stat_pkg::ST_REMOVED);
                    end
                    else
                    begin
                        // close the gap: move later entries down
                        rd_en   = 1'b1;
                        rd_addr = IDX_W'(idx_inc);
                        j_next  = IDX_W'(idx_inc);
                    end
                end
                else
                begin
                    if (full)
                    begin
                        pend_next = stat_pkg::status_res(stat_pkg::ST_FULL);
                    end
                    else
                    begin
                        // open a gap at idx: move entries up from the tail
                        rd_en   = 1'b1;
                        rd_addr = IDX_W'(count_reg - CNT_W'(1));
                        j_next  = IDX_W'(count_reg - CNT_W'(1));
                    end
                end
            end
            stat_pkg::S_UP:
            begin
                wr_en    = 1'b1;
                wr_addr  = IDX_W'(j_inc);
                wr_entry = rd_entry;
                if (!j_at_pos)
                begin
                    rd_en   = 1'b1;
                    rd_addr = j_reg - IDX_W'(1);
                    j_next  = j_reg - IDX_W'(1);
                end
            end
            stat_pkg::S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                count_next = count_reg + CNT_W'(1);
                pend_next  = stat_pkg::status_res(stat_pkg::ST_NEW);
            end
            stat_pkg::S_DN:
            begin
                wr_en    = 1'b1;
                wr_addr  = j_reg - IDX_W'(1);
                wr_entry = rd_entry;
                if (j_at_end)
                begin
                    count_next = count_reg - CNT_W'(1);
                    pend_next  = stat_pkg::status_res(stat_pkg::ST_REMOVED);
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(j_inc);
                    j_next  = IDX_W'(j_inc);
                end
            end
            stat_pkg::S_DUMP:
            begin
                res_valid  = 1'b1;
                res.status = stat_pkg::ST_TERM;
                res.coef   = rd_entry.coef;
                res.exp    = rd_entry.exp;
                res.last   = dump_end;
                if (res_ready && !dump_end)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = IDX_W'(idx_inc);
                    idx_next = IDX_W'(idx_inc);
                end
            end
            stat_pkg::S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stat_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        j_reg    <= j_next;
        coef_reg <= coef_next;
        exp_reg  <= exp_next;
        pend_reg <= pend_next;
    end

endmodule

// ----- hdl/stat_checker.sv -----
`include "sorted_term_accumulate_table_macros.svh"

module stat_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // Only defined status codes leave the block
    `STAT_ASSERT_NOW(a_status_range, m_tvalid, m_tuser <= stat_pkg::ST_CLEARED)

    // Anything but a dumped term is the sole result of its item
    `STAT_ASSERT_NOW(a_single_last, m_tvalid && m_tuser != stat_pkg::ST_TERM, m_tlast)

    // Term fields are zero outside a dump
    `STAT_ASSERT_NOW(a_zero_fields, m_tvalid && m_tuser != stat_pkg::ST_TERM, m_tdata == '0)

    // A stalled result holds
    `STAT_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind sorted_term_accumulate_table stat_checker u_stat_checker (.*);
